FILE: sv/wfpa_pkg.sv
// ----------------------------------------------------------------------------
// Worst-fit partition allocator package
// Operation codes, field widths and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package wfpa_pkg;

  // Fixed field widths of the stream payload and the configuration register.
  localparam int OP_W    = 2;
  localparam int IDX_W   = 4;
  localparam int REQ_W   = 16;
  localparam int CNT_W   = 5;
  localparam int TDATA_W = 24;

  // Reset value of the active partition count.
  localparam logic [CNT_W-1:0] COUNT_RESET = 5'd16;

  // Operation codes carried on the input tuser.
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;     // capture the input transfer, restart the scan
    logic rd_idx;      // read the table entry addressed by the item
    logic scan_issue;  // read the next entry of the allocation scan
    logic commit;      // write back and load the output register
  } wfpa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] in_op;
    logic            active_zero;
    logic            scan_last;
    logic            out_free;
  } wfpa_sts_t;

endpackage

FILE: sv/wfpa_ctrl.sv
// ----------------------------------------------------------------------------
// Worst-fit partition allocator controller
// Sequences one item at a time: capture, a table read for a read or a scan for
// an allocate with active partitions, then commit once the output register is free.
// ----------------------------------------------------------------------------
module wfpa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  wfpa_pkg::wfpa_sts_t sts,
  output wfpa_pkg::wfpa_cmd_t cmd
);
  import wfpa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RDREQ  = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_COMMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          if (sts.in_op == OP_READ) begin
            state_nxt = S_RDREQ;
          end else if (sts.in_op == OP_ALLOC && !sts.active_zero) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_COMMIT;
          end
        end
      end
      S_RDREQ: begin
        cmd.rd_idx = 1'b1;
        state_nxt  = S_COMMIT;
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/wfpa_dp.sv
// ----------------------------------------------------------------------------
// Worst-fit partition allocator datapath
// Partition table memory, used marks, scan comparator with best-entry
// registers, the count register and the output register.
// ----------------------------------------------------------------------------
module wfpa_dp #(
  parameter int PARTITIONS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [wfpa_pkg::CNT_W-1:0]    cfg_wr_data,
  input  logic [wfpa_pkg::TDATA_W-1:0]  in_tdata,
  input  logic [wfpa_pkg::OP_W-1:0]     in_tuser,
  input  wfpa_pkg::wfpa_cmd_t           cmd,
  output wfpa_pkg::wfpa_sts_t           sts,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [wfpa_pkg::TDATA_W-1:0]  out_tdata,
  output logic                          out_tuser
);
  import wfpa_pkg::*;

  localparam int AW   = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int CMPW = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;
  localparam int SW   = 9;

  localparam logic [SW-1:0]   PART_N    = SW'(PARTITIONS);
  localparam logic [CMPW-1:0] SPACE_MAX = CMPW'({SIZE_BITS{1'b1}});

  // Configuration and captured item.
  logic [CNT_W-1:0]     count_r;
  logic [OP_W-1:0]      op_r;
  logic [IDX_W-1:0]     idx_r;
  logic [REQ_W-1:0]     req_r;

  // Table storage.
  logic [SIZE_BITS-1:0] mem [PARTITIONS];
  logic [SIZE_BITS-1:0] rd_data_r;
  logic [PARTITIONS-1:0] used_r;

  // Scan state.
  logic [SW-1:0]        scan_r;
  logic                 cmp_v_r;
  logic [AW-1:0]        cmp_idx_r;
  logic                 found_r;
  logic [AW-1:0]        best_idx_r;
  logic [SIZE_BITS-1:0] best_left_r;

  // Output register.
  logic                 out_valid_r;
  logic [TDATA_W-1:0]   out_data_r;
  logic                 out_user_r;

  logic [SW-1:0]        cnt_ext;
  logic [SW-1:0]        active;
  logic                 idx_ok;
  logic [AW-1:0]        idx_a;
  logic [CMPW-1:0]      req_ext;
  logic [CMPW-1:0]      fs_ext;
  logic [CMPW-1:0]      left;
  logic                 fits;
  logic [SIZE_BITS-1:0] load_val;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 mem_we;
  logic                 used_we;
  logic                 used_val;
  logic [AW-1:0]        wr_addr;
  logic [SIZE_BITS-1:0] wr_data;
  logic                 res_granted;
  logic [IDX_W-1:0]     res_idx;
  logic [REQ_W-1:0]     res_space;
  logic                 res_used;

  // Active count limited to the table size, and item index decode.
  assign cnt_ext = SW'(count_r);
  assign active  = (cnt_ext > PART_N) ? PART_N : cnt_ext;
  assign idx_ok  = SW'(idx_r) < PART_N;
  assign idx_a   = AW'(idx_r);
  assign req_ext = CMPW'(req_r);

  // A load saturates the size to what an entry can hold.
  assign load_val = (req_ext > SPACE_MAX) ? SIZE_BITS'(SPACE_MAX) : SIZE_BITS'(req_ext);

  // Scan comparator on the entry read in the previous cycle.
  assign fs_ext = CMPW'(rd_data_r);
  assign fits   = fs_ext >= req_ext;
  assign left   = fs_ext - req_ext;

  // Status to the controller.
  assign sts.in_op       = in_tuser;
  assign sts.active_zero = (active == '0);
  assign sts.scan_last   = (scan_r + SW'(1)) == active;
  assign sts.out_free    = !out_valid_r || out_tready;

  // Memory read port shared by the scan and the read operation.
  assign rd_en   = cmd.rd_idx || cmd.scan_issue;
  assign rd_addr = cmd.scan_issue ? scan_r[AW-1:0] : idx_a;

  // Result and write-back for the committed item.
  always_comb begin
    mem_we      = 1'b0;
    used_we     = 1'b0;
    used_val    = 1'b0;
    wr_addr     = idx_a;
    wr_data     = load_val;
    res_granted = 1'b0;
    res_idx     = idx_r;
    res_space   = '0;
    res_used    = 1'b0;
    case (op_r)
      OP_LOAD: begin
        if (idx_ok) begin
          mem_we      = 1'b1;
          used_we     = 1'b1;
          res_granted = 1'b1;
          res_space   = REQ_W'(load_val);
        end
      end
      OP_ALLOC: begin
        res_idx = '0;
        if (found_r) begin
          mem_we      = 1'b1;
          used_we     = 1'b1;
          used_val    = 1'b1;
          wr_addr     = best_idx_r;
          wr_data     = best_left_r;
          res_granted = 1'b1;
          res_idx     = IDX_W'(best_idx_r);
          res_space   = REQ_W'(best_left_r);
          res_used    = 1'b1;
        end
      end
      OP_READ: begin
        if (idx_ok) begin
          res_granted = 1'b1;
          res_space   = REQ_W'(rd_data_r);
          res_used    = used_r[idx_a];
        end
      end
      OP_NONE: begin
        res_idx = '0;
      end
      default: begin
        res_idx = '0;
      end
    endcase
  end

  // Partition table memory with registered read data.
  always_ff @(posedge clk) begin
    if (cmd.commit && mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Used marks, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.commit && used_we) begin
      used_r[wr_addr] <= used_val;
    end
  end

  // Active partition count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
    end else if (cfg_wr_en) begin
      count_r <= cfg_wr_data;
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_tuser;
      idx_r <= in_tdata[IDX_W-1:0];
      req_r <= in_tdata[IDX_W+REQ_W-1:IDX_W];
    end
  end

  // Scan counter, compare stage valid and best-entry tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r  <= '0;
      cmp_v_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      cmp_v_r <= cmd.scan_issue;
      if (cmd.load_in) begin
        scan_r  <= '0;
        found_r <= 1'b0;
      end else begin
        if (cmd.scan_issue) begin
          scan_r <= scan_r + SW'(1);
        end
        if (cmp_v_r && fits && (!found_r || SIZE_BITS'(left) > best_left_r)) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_issue) begin
      cmp_idx_r <= scan_r[AW-1:0];
    end
    if (cmp_v_r && fits && (!found_r || SIZE_BITS'(left) > best_left_r)) begin
      best_idx_r  <= cmp_idx_r;
      best_left_r <= SIZE_BITS'(left);
    end
  end

  // Output register: a transfer frees it, a commit fills it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= {3'b000, res_used, res_space, res_idx};
      out_user_r <= res_granted;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // A result never overwrites one that is still waiting.
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_tready))
    else $error("commit while the output register is occupied");

  // The compare stage only sees data from a scan read.
  a_cmp_source: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_v_r |-> $past(cmd.scan_issue))
    else $error("compare stage valid without a scan read");

  // A granted allocation leaves its partition marked used.
  a_alloc_used: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && op_r == OP_ALLOC && found_r) |=> used_r[best_idx_r])
    else $error("allocated partition not marked used");

  // The scan never runs past the active partitions.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_issue |-> (scan_r < active))
    else $error("scan read beyond the active partitions");

endmodule

FILE: sv/worst_fit_partition_allocator_unit.sv
// Flow: a load, an unused op and an allocate with no active partition go from
// capture straight to commit; a read first reads its table entry; other allocates
// scan the active partitions, active being the partition count limited to PARTITIONS.
// Throughput: one item at a time; the scan reads one table entry per cycle
// through the single read port, and a new item is taken only once the last commits.
// Reset clears the used marks and sets the count to 16.
// ----------------------------------------------------------------------------
// Worst-fit partition allocator
// Stream-facing top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
module worst_fit_partition_allocator_unit #(
  parameter int PARTITIONS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [wfpa_pkg::CNT_W-1:0]   cfg_wr_data,   // partition_count
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [wfpa_pkg::TDATA_W-1:0] in_tdata,      // partition_index[3:0], request_size[19:4]
  input  logic [wfpa_pkg::OP_W-1:0]    in_tuser,      // operation[1:0]
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [wfpa_pkg::TDATA_W-1:0] out_tdata,     // chosen_partition[3:0],
                                                      // remaining_space[19:4], in_use[20]
  output logic                         out_tuser      // granted[0]
);
  import wfpa_pkg::*;

  wfpa_cmd_t cmd;
  wfpa_sts_t sts;

  // Control sequencer.
  wfpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Table, scan and output datapath.
  wfpa_dp #(
    .PARTITIONS (PARTITIONS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule
